/* rtl/sbfd_pkg.sv */
// Shared constants and types for the SBUS frame decoder.
// No dependencies; every other file of the block uses this package.
`timescale 1ns / 1ps

package sbfd_pkg;

  localparam int FRAME_BYTES     = 25;
  localparam int NUM_CHANNELS    = 16;
  localparam int CHAN_BITS       = 11;
  localparam int CHAN_BYTES      = 22;
  localparam int CHAN_STORE_BITS = CHAN_BYTES * 8;
  localparam int COUNT_BITS      = 5;
  localparam int INDEX_BITS      = 4;

  // Positions inside the frame.
  localparam logic [COUNT_BITS-1:0] POS_FIRST_CHAN = COUNT_BITS'(1);
  localparam logic [COUNT_BITS-1:0] POS_LAST_CHAN  = COUNT_BITS'(CHAN_BYTES);
  localparam logic [COUNT_BITS-1:0] POS_FLAGS      = COUNT_BITS'(FRAME_BYTES - 2);
  localparam logic [COUNT_BITS-1:0] POS_END        = COUNT_BITS'(FRAME_BYTES - 1);

  localparam logic [7:0] START_BYTE = 8'h0F;
  localparam logic [7:0] END_BYTE   = 8'h00;

  localparam logic [INDEX_BITS-1:0] LAST_INDEX = INDEX_BITS'(NUM_CHANNELS - 1);

  typedef logic [7:0]              byte_t;
  typedef logic [CHAN_BITS-1:0]    chan_value_t;
  typedef logic [INDEX_BITS-1:0]   chan_index_t;
  typedef logic [COUNT_BITS-1:0]   count_t;

  // Handoff from the collector to the emitter for one finished frame.
  typedef struct packed {
    logic load;
    logic connected;
  } frame_ctrl_t;

endpackage

/* rtl/sbfd_if.sv */
// Valid/ready channel interfaces for the SBUS frame decoder.
// Depends on sbfd_pkg for the payload types.
`timescale 1ns / 1ps

interface sbfd_byte_if;
  logic           valid;
  logic           ready;
  sbfd_pkg::byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sbfd_chan_if;
  logic                  valid;
  logic                  ready;
  sbfd_pkg::chan_index_t channel_index;
  sbfd_pkg::chan_value_t channel_value;
  logic                  connected;
  logic                  last;

  modport source (output valid, output channel_index, output channel_value,
                  output connected, output last, input ready);
  modport sink   (input valid, input channel_index, input channel_value,
                  input connected, input last, output ready);
endinterface

/* rtl/sbfd_collector.sv */
// Frame collector: hunts for the start byte, shifts in the channel bytes,
// keeps the flags byte and checks the end byte. Depends on sbfd_pkg.
`timescale 1ns / 1ps

module sbfd_collector (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   rx_valid,
  output logic                                   rx_ready,
  input  sbfd_pkg::byte_t                        rx_byte,
  input  logic                                   emit_busy,
  output sbfd_pkg::frame_ctrl_t                  ctrl,
  output logic [sbfd_pkg::CHAN_STORE_BITS-1:0]   chan_bits
);
  import sbfd_pkg::*;

  count_t byte_count;
  count_t byte_count_next;
  byte_t  flags;
  logic   accept;

  // The closing byte waits while the emitter still holds the previous frame.
  assign rx_ready = (byte_count != POS_END) || !emit_busy;
  assign accept   = rx_valid && rx_ready;

  always_comb begin
    byte_count_next = byte_count;
    if (byte_count == '0) begin
      if (rx_byte == START_BYTE) begin
        byte_count_next = POS_FIRST_CHAN;
      end
    end else if (byte_count == POS_END) begin
      byte_count_next = '0;
    end else begin
      byte_count_next = byte_count + count_t'(1);
    end
  end

  always_comb begin
    ctrl.load      = accept && (byte_count == POS_END) && (rx_byte == END_BYTE);
    ctrl.connected = (flags == 8'h00);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
    end else if (accept) begin
      byte_count <= byte_count_next;
    end
  end

  // Channel bytes enter at the top, so byte 1 ends up in the low byte.
  always_ff @(posedge clk) begin
    if (accept && byte_count >= POS_FIRST_CHAN && byte_count <= POS_LAST_CHAN) begin
      chan_bits <= {rx_byte, chan_bits[CHAN_STORE_BITS-1:8]};
    end
    if (accept && byte_count == POS_FLAGS) begin
      flags <= rx_byte;
    end
  end

endmodule

/* rtl/sbfd_emitter.sv */
// Result emitter: holds one decoded frame and hands out its channel words
// one per accepted output word. Depends on sbfd_pkg.
`timescale 1ns / 1ps

module sbfd_emitter (
  input  logic                                   clk,
  input  logic                                   rst,
  input  sbfd_pkg::frame_ctrl_t                  ctrl,
  input  logic [sbfd_pkg::CHAN_STORE_BITS-1:0]   chan_bits,
  output logic                                   busy,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output sbfd_pkg::chan_index_t                  channel_index,
  output sbfd_pkg::chan_value_t                  channel_value,
  output logic                                   connected,
  output logic                                   last
);
  import sbfd_pkg::*;

  logic [CHAN_STORE_BITS-1:0] shift;
  chan_index_t                index;
  logic                       conn;
  logic                       out_accept;

  assign out_valid     = busy;
  assign out_accept    = busy && out_ready;
  assign connected     = conn;
  assign channel_index = conn ? index : '0;
  assign channel_value = conn ? shift[CHAN_BITS-1:0] : '0;
  assign last          = !conn || (index == LAST_INDEX);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (ctrl.load) begin
      busy <= 1'b1;
    end else if (out_accept && last) begin
      busy <= 1'b0;
    end
  end

  // Each accepted word drops the lowest channel and moves to the next one.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      shift <= chan_bits;
      index <= '0;
      conn  <= ctrl.connected;
    end else if (out_accept) begin
      shift <= shift >> CHAN_BITS;
      index <= index + chan_index_t'(1);
    end
  end

endmodule

/* rtl/sbus_frame_decoder.sv */
// SBUS frame decoder, top level. Takes one received byte word per cycle unless
// the closing byte stalls; the first result word shows in the cycle after the
// 25th frame byte is taken. Gives one result word per cycle while the sink is
// ready, so a connected frame drains its 16 words from the emitter register.
// Reset (rst, synchronous, active high) returns the decoder to start-byte hunting
// and drops any result still held; frame bytes need no clearing.
`timescale 1ns / 1ps

module sbus_frame_decoder (
  input  logic               clk,
  input  logic               rst,
  sbfd_byte_if.sink          rx,
  sbfd_chan_if.source        chan
);
  import sbfd_pkg::*;

  // The collector and the emitter run concurrently: bytes of the next frame
  // are taken while the previous frame's channel words are still draining.
  // Only the closing byte of a frame can stall, and only when the emitter
  // still holds words that the sink has not taken.

  frame_ctrl_t                ctrl;
  logic [CHAN_STORE_BITS-1:0] chan_bits;
  logic                       emit_busy;

  sbfd_collector u_collector (
    .clk       (clk),
    .rst       (rst),
    .rx_valid  (rx.valid),
    .rx_ready  (rx.ready),
    .rx_byte   (rx.rx_byte),
    .emit_busy (emit_busy),
    .ctrl      (ctrl),
    .chan_bits (chan_bits)
  );

  // The emitter's registers are the output register: a frame with a good end
  // byte is copied in whole, and a nonzero flags byte yields one word with
  // connected low, index and value zero, and last high.
  sbfd_emitter u_emitter (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl),
    .chan_bits     (chan_bits),
    .busy          (emit_busy),
    .out_valid     (chan.valid),
    .out_ready     (chan.ready),
    .channel_index (chan.channel_index),
    .channel_value (chan.channel_value),
    .connected     (chan.connected),
    .last          (chan.last)
  );

endmodule

/* rtl/sbfd_checker.sv */
// Port-level checks for the SBUS frame decoder, bound to the top level.
// Depends on sbfd_pkg and on the port signals of sbus_frame_decoder.
`timescale 1ns / 1ps

module sbfd_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  out_valid,
  input logic                  out_ready,
  input sbfd_pkg::chan_index_t channel_index,
  input sbfd_pkg::chan_value_t channel_value,
  input logic                  connected,
  input logic                  last
);
  import sbfd_pkg::*;

  // A stalled word stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output word withdrawn while stalled");

  // A frame's words come without gaps until the last one is taken.
  a_frame_unbroken: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=>
      out_valid && connected && channel_index == $past(channel_index) + chan_index_t'(1))
    else $error("channel sequence broken inside a frame");

  // A disconnected frame gives one word with zero index and value.
  a_disconnected: assert property (@(posedge clk) disable iff (rst)
    out_valid && !connected |-> last && channel_index == '0 && channel_value == '0)
    else $error("bad word for a frame with nonzero flags");

  // On a connected frame, last marks channel 15 and nothing else.
  a_last_marks_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && connected |-> (last == (channel_index == LAST_INDEX)))
    else $error("last flag does not match the final channel");

endmodule

bind sbus_frame_decoder sbfd_checker u_sbfd_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (chan.valid),
  .out_ready     (chan.ready),
  .channel_index (chan.channel_index),
  .channel_value (chan.channel_value),
  .connected     (chan.connected),
  .last          (chan.last)
);

/* sim/sbus_frame_decoder_test.sv */
// Self-checking testbench for the SBUS frame decoder (sbus_frame_decoder).
// Depends on rtl/sbfd_pkg.sv, rtl/sbfd_if.sv and the decoder RTL; it drives bytes
// and checks every channel word against its own frame decoder.
`timescale 1ns / 1ps

module sbus_frame_decoder_test;
  import sbfd_pkg::*;

  localparam int CLK_PERIOD      = 8;
  localparam int RESET_CYCLES    = 8;
  localparam int TARGET_BYTES    = 290;   // frame bytes in the random part
  localparam int TAIL_BYTES      = 80;    // last stretch of bytes sent with no idling
  localparam int HOLD_AT_WORDS   = 40;    // channel words seen before the long hold-off
  localparam int HOLD_CYCLES     = 300;   // length of the long hold-off on the result side
  localparam int DRAIN_CYCLES    = 40;    // quiet cycles after the last expected word
  localparam int WATCHDOG_CYCLES = 2000;  // cycles without any word moving before giving up

  // How the 22 channel bytes of a generated frame are filled.
  typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_MIXED} fill_t;

  // One channel word as the decoder presents it.
  typedef struct packed {
    chan_index_t index;
    chan_value_t value;
    logic        connected;
    logic        last;
  } channel_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sbfd_byte_if byte_bus ();
  sbfd_chan_if chan_bus ();

  sbus_frame_decoder dut (
    .clk  (clk),
    .rst  (rst),
    .rx   (byte_bus.sink),
    .chan (chan_bus.source)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Bytes waiting to be offered, and channel words the decoder still owes us.
  byte_t         bytes_to_send [$];
  channel_word_t channel_words_due [$];

  // State of the testbench's own decoder: how many bytes of the current frame
  // have been collected, and the bytes themselves.
  count_t frame_fill = '0;
  byte_t  frame_bytes [FRAME_BYTES];

  int   stim_total   = 0;
  int   bytes_taken  = 0;
  int   words_seen   = 0;
  int   error_count  = 0;
  int   stall_cycles = 0;
  int   send_gap     = 0;
  int   recv_gap     = 0;
  int   hold_left    = 0;
  logic hold_done    = 1'b0;
  logic rx_fire      = 1'b0;

  // Idling stops for the last stretch of bytes so the run ends at full rate.
  logic tail_phase;
  assign tail_phase = (bytes_taken >= stim_total - TAIL_BYTES);

  // Feeds one accepted byte through the decoder and queues the channel words it
  // causes. Hunting drops everything except the start byte. A full frame with a
  // bad end byte is dropped. A nonzero flags byte gives one disconnected word;
  // otherwise the 22 channel bytes form a little-endian bit string from which
  // sixteen 11-bit channels are cut, LSB first.
  task automatic decode_byte(input byte_t rx_value);
    logic [CHAN_STORE_BITS-1:0] chan_bits;
    channel_word_t              word;
    if (frame_fill == '0 && rx_value != START_BYTE) return;
    frame_bytes[frame_fill] = rx_value;
    frame_fill = frame_fill + 1'b1;
    if (frame_fill < FRAME_BYTES) return;
    frame_fill = '0;
    if (frame_bytes[POS_END] != END_BYTE) return;
    if (frame_bytes[POS_FLAGS] != 8'h00) begin
      word.index     = '0;
      word.value     = '0;
      word.connected = 1'b0;
      word.last      = 1'b1;
      channel_words_due.push_back(word);
      return;
    end
    for (int i = 0; i < CHAN_BYTES; i++) begin
      chan_bits[8*i +: 8] = frame_bytes[int'(POS_FIRST_CHAN) + i];
    end
    for (int k = 0; k < NUM_CHANNELS; k++) begin
      word.index     = chan_index_t'(k);
      word.value     = chan_bits[CHAN_BITS*k +: CHAN_BITS];
      word.connected = 1'b1;
      word.last      = (chan_index_t'(k) == LAST_INDEX);
      channel_words_due.push_back(word);
    end
  endtask

  // Appends one complete frame: start byte, 22 channel bytes, flags, end byte.
  task automatic queue_frame(input fill_t fill, input byte_t flags, input byte_t end_value);
    byte_t data;
    bytes_to_send.push_back(START_BYTE);
    for (int i = 0; i < CHAN_BYTES; i++) begin
      case (fill)
        FILL_ZERO: data = 8'h00;
        FILL_ONES: data = 8'hFF;
        FILL_MIXED: begin
          case ($urandom_range(0, 2))
            0: data = 8'h00;
            1: data = 8'hFF;
            default: data = 8'($urandom_range(0, 255));
          endcase
        end
        default: data = 8'($urandom_range(0, 255));
      endcase
      bytes_to_send.push_back(data);
    end
    bytes_to_send.push_back(flags);
    bytes_to_send.push_back(end_value);
  endtask

  // Stimulus, reset and the end of the run.
  initial begin
    int    counted;
    int    pick;
    int    span;
    byte_t noise;
    byte_t flags;
    byte_t end_value;

    // Directed part. Hunting noise first: none of these is the start byte, so
    // all of them are dropped.
    bytes_to_send.push_back(8'h00);
    bytes_to_send.push_back(8'hFF);
    bytes_to_send.push_back(8'h0E);
    bytes_to_send.push_back(8'h8F);
    // All channel bits set: every channel reads full scale.
    queue_frame(FILL_ONES, 8'h00, END_BYTE);
    // All channel bits clear: every channel reads zero.
    queue_frame(FILL_ZERO, 8'h00, END_BYTE);
    // Flags nonzero (lowest and highest bit alone): one disconnected word each.
    queue_frame(FILL_RANDOM, 8'h01, END_BYTE);
    queue_frame(FILL_ONES, 8'h80, END_BYTE);
    // Bad end byte: the whole frame is dropped silently.
    queue_frame(FILL_RANDOM, 8'h00, 8'hFF);
    queue_frame(FILL_MIXED, 8'h0C, 8'h01);
    // A normal frame with random channel data right after the dropped ones.
    queue_frame(FILL_RANDOM, 8'h00, END_BYTE);

    // Random part: mostly well-formed frames with random content, plus noise
    // between frames and truncated frames that are padded out with 0xFF so the
    // padded frame fails on its end byte and hunting resumes cleanly.
    counted = 0;
    while (counted < TARGET_BYTES) begin
      pick = $urandom_range(0, 19);
      if (pick < 2) begin
        repeat ($urandom_range(1, 3)) begin
          noise = 8'($urandom_range(0, 255));
          if (noise == START_BYTE) noise = START_BYTE ^ 8'h80;
          bytes_to_send.push_back(noise);
        end
      end else if (pick == 2) begin
        span = $urandom_range(1, FRAME_BYTES - 2);
        bytes_to_send.push_back(START_BYTE);
        repeat (span) bytes_to_send.push_back(8'($urandom_range(0, 255)));
        repeat (FRAME_BYTES - 1 - span) bytes_to_send.push_back(8'hFF);
        counted += FRAME_BYTES;
      end else begin
        flags     = ($urandom_range(0, 9) < 3) ? 8'($urandom_range(1, 255)) : 8'h00;
        end_value = ($urandom_range(0, 9) < 2) ? 8'($urandom_range(1, 255)) : END_BYTE;
        case ($urandom_range(0, 9))
          0:       queue_frame(FILL_ZERO, flags, end_value);
          1:       queue_frame(FILL_ONES, flags, end_value);
          2, 3:    queue_frame(FILL_MIXED, flags, end_value);
          default: queue_frame(FILL_RANDOM, flags, end_value);
        endcase
        counted += FRAME_BYTES;
      end
    end
    stim_total = bytes_to_send.size();

    // Reset is held at first and released on a falling edge.
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Wait for every byte to be taken and every owed word to arrive, then let the
    // decoder run quiet to show any word it should not produce.
    while (bytes_taken < stim_total || channel_words_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Byte driver: changes on the falling edge. A word on offer stays put until
  // it is taken; between words it idles now and then.
  always @(negedge clk) begin
    if (rst) begin
      byte_bus.valid   <= 1'b0;
      byte_bus.rx_byte <= '0;
      send_gap         <= 0;
    end else if (byte_bus.valid && !rx_fire) begin
      // Still waiting for the decoder to take the current word.
    end else if (send_gap > 0) begin
      send_gap       <= send_gap - 1;
      byte_bus.valid <= 1'b0;
    end else if (!tail_phase && $urandom_range(0, 5) == 0) begin
      send_gap       <= $urandom_range(0, 3);
      byte_bus.valid <= 1'b0;
    end else if (bytes_to_send.size() > 0) begin
      byte_bus.valid   <= 1'b1;
      byte_bus.rx_byte <= bytes_to_send.pop_front();
    end else begin
      byte_bus.valid <= 1'b0;
    end
  end

  // Result-side ready: short random stalls, and once in the run a long hold-off
  // while bytes keep coming, so the decoder backs up and stalls its input.
  always @(negedge clk) begin
    if (rst) begin
      chan_bus.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left      <= hold_left - 1;
      chan_bus.ready <= 1'b0;
    end else if (!hold_done && words_seen >= HOLD_AT_WORDS) begin
      hold_done      <= 1'b1;
      hold_left      <= HOLD_CYCLES - 1;
      chan_bus.ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap       <= recv_gap - 1;
      chan_bus.ready <= 1'b0;
    end else if (!tail_phase && $urandom_range(0, 5) == 0) begin
      recv_gap       <= $urandom_range(0, 3);
      chan_bus.ready <= 1'b0;
    end else begin
      chan_bus.ready <= 1'b1;
    end
  end

  // Monitor on the rising edge. Channel words are checked before the byte of
  // the same edge is decoded; a word can never depend on a byte taken at the
  // same edge, so the order only keeps the queue tidy.
  always @(posedge clk) begin
    channel_word_t want;
    if (rst) begin
      rx_fire <= 1'b0;
    end else begin
      rx_fire <= byte_bus.valid && byte_bus.ready;
      if (chan_bus.valid && chan_bus.ready) begin
        words_seen <= words_seen + 1;
        if (channel_words_due.size() == 0) begin
          $error("unexpected channel word: channel_index %0d channel_value %0d connected %0b",
                 chan_bus.channel_index, chan_bus.channel_value, chan_bus.connected);
          error_count++;
        end else begin
          want = channel_words_due.pop_front();
          if (chan_bus.channel_index !== want.index) begin
            $error("channel_index: expected %0d, got %0d", want.index, chan_bus.channel_index);
            error_count++;
          end
          if (chan_bus.channel_value !== want.value) begin
            $error("channel_value: expected %0d, got %0d", want.value, chan_bus.channel_value);
            error_count++;
          end
          if (chan_bus.connected !== want.connected) begin
            $error("connected: expected %0b, got %0b", want.connected, chan_bus.connected);
            error_count++;
          end
          if (chan_bus.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, chan_bus.last);
            error_count++;
          end
        end
      end
      if (byte_bus.valid && byte_bus.ready) begin
        bytes_taken <= bytes_taken + 1;
        decode_byte(byte_bus.rx_byte);
      end
    end
  end

  // Watchdog: any word moving on either side restarts the count.
  always @(posedge clk) begin
    if (rst || (byte_bus.valid && byte_bus.ready) || (chan_bus.valid && chan_bus.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule
